[sv/mwsm_pkg.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer package
// Widths, constants and lane types shared by the mixer cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsm_pkg;

    localparam int unsigned InW       = 16;
    localparam int unsigned MW        = 18;   // raw wheel, signed
    localparam int unsigned NumWheels = 4;
    localparam int unsigned RootW     = 22;   // isqrt of (x^2 + y^2) << 12
    localparam int unsigned RadW      = 2 * RootW;
    localparam int unsigned RemSW     = RootW + 1;
    localparam int unsigned SqW       = 32;   // x^2 + y^2
    localparam int unsigned DenW      = 23;   // Q6 normalizing sum
    localparam int unsigned RemDW     = DenW;
    localparam int unsigned QW        = 17;   // quotient magnitude bits
    localparam int unsigned ProdW     = MW + InW;
    localparam int unsigned OutW      = 21;
    localparam int unsigned SqrtCells = RootW;
    localparam int unsigned DivCells  = QW;

    localparam logic [16:0]              InvSqrt2   = 17'd46341;  // 1/sqrt2 in Q16
    localparam logic [InW-1:0]           ScaleReset = 16'd256;    // 1.0 in Q8.8
    localparam logic signed [OutW-1:0]   OutMax     = 21'sd524288;
    localparam logic signed [OutW-1:0]   OutMin     = -21'sd524288;

    typedef struct packed {
        logic [RadW-1:0]                 rad;
        logic [RemSW-1:0]                rem;
        logic [RootW-1:0]                root;
        logic [NumWheels-1:0][MW-1:0]    m;
        logic [InW-1:0]                  aw;
        logic                            limited;
    } t_sqrt_lane;

    typedef struct packed {
        logic [DenW-1:0]                 den;
        logic [NumWheels-1:0][RemDW-1:0] rem;
        logic [NumWheels-1:0][QW-1:0]    nb;
        logic [NumWheels-1:0][QW-1:0]    q;
        logic [NumWheels-1:0][MW-1:0]    m;
        logic [NumWheels-1:0]            neg;
        logic                            limited;
    } t_div_lane;

endpackage

`default_nettype wire

[sv/mwsm_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cell and passes the lane to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_sqrt_cell (
    input  wire logic                i_clk,
    input  wire logic                i_ce,
    input  wire mwsm_pkg::t_sqrt_lane i_lane,
    output mwsm_pkg::t_sqrt_lane     o_lane
);

    logic [mwsm_pkg::RemSW+1:0] trem;
    logic [mwsm_pkg::RemSW+1:0] trial;
    logic [mwsm_pkg::RemSW+1:0] diff;
    mwsm_pkg::t_sqrt_lane       n_lane;
    mwsm_pkg::t_sqrt_lane       r_lane;

    always_comb begin
        n_lane = i_lane;
        trem   = {i_lane.rem, i_lane.rad[mwsm_pkg::RadW-1 -: 2]};
        trial  = {{(mwsm_pkg::RemSW - mwsm_pkg::RootW){1'b0}}, i_lane.root, 2'b01};
        diff   = trem - trial;
        n_lane.rad = {i_lane.rad[mwsm_pkg::RadW-3:0], 2'b00};
        if (trem >= trial) begin
            n_lane.rem  = diff[mwsm_pkg::RemSW-1:0];
            n_lane.root = {i_lane.root[mwsm_pkg::RootW-2:0], 1'b1};
        end else begin
            n_lane.rem  = trem[mwsm_pkg::RemSW-1:0];
            n_lane.root = {i_lane.root[mwsm_pkg::RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

[sv/mwsm_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit for all four wheels and passes the lane on.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_div_cell (
    input  wire logic               i_clk,
    input  wire logic               i_ce,
    input  wire mwsm_pkg::t_div_lane i_lane,
    output mwsm_pkg::t_div_lane     o_lane
);

    logic [mwsm_pkg::RemDW:0] trem [mwsm_pkg::NumWheels];
    logic [mwsm_pkg::RemDW:0] diff [mwsm_pkg::NumWheels];
    mwsm_pkg::t_div_lane      n_lane;
    mwsm_pkg::t_div_lane      r_lane;

    always_comb begin
        n_lane = i_lane;
        for (int i = 0; i < mwsm_pkg::NumWheels; i++) begin
            trem[i] = {i_lane.rem[i], i_lane.nb[i][mwsm_pkg::QW-1]};
            diff[i] = trem[i] - {1'b0, i_lane.den};
            n_lane.nb[i] = {i_lane.nb[i][mwsm_pkg::QW-2:0], 1'b0};
            if (trem[i] >= {1'b0, i_lane.den}) begin
                n_lane.rem[i] = diff[i][mwsm_pkg::RemDW-1:0];
                n_lane.q[i]   = {i_lane.q[i][mwsm_pkg::QW-2:0], 1'b1};
            end else begin
                n_lane.rem[i] = trem[i][mwsm_pkg::RemDW-1:0];
                n_lane.q[i]   = {i_lane.q[i][mwsm_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

[sv/mecanum_wheel_speed_mixer_top.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel speed mixer
// Turns (x, y, yaw) velocity commands into four scaled wheel commands,
// normalized when limited, through a chain of square root and divider cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  s         in         i_s_tvalid/o_s_tready   lin_x, lin_y, ang_z
//  m         out        o_m_tvalid/i_m_tready   four wheels, was_limited
//  cfg       in         i_cfg_valid/o_cfg_ready speed_scale
//
//  One command enters per cycle while m is not stalled; each result passes
//  through 45 register stages: 22 square root cells, 17 divider cells
//  and 6 arithmetic stages.
//  Reset clears the stage valid bits and sets speed_scale to 1.0.
//  A stall on m freezes the whole chain; the input stage still takes one
//  transfer while it is empty, after that the input waits for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_speed_mixer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // lin_x, lin_y, ang_z
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [87:0]      o_m_tdata,   // front_left, front_right, rear_left,
                                          // rear_right, was_limited, zero pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data   // speed_scale
);

    localparam int unsigned SqBase  = 3;
    localparam int unsigned DStage  = SqBase + mwsm_pkg::SqrtCells;
    localparam int unsigned DivBase = DStage + 1;
    localparam int unsigned EStage  = DivBase + mwsm_pkg::DivCells;
    localparam int unsigned NStages = EStage + 2;

    localparam int unsigned MW = mwsm_pkg::MW;
    localparam int unsigned NW = mwsm_pkg::NumWheels;

    // ---- control ----
    logic               ce;
    logic               en0;
    logic [NStages-1:0] r_v;
    logic [15:0]        r_speed_scale;

    assign ce          = !r_v[NStages-1] || i_m_tready;
    assign en0         = ce || !r_v[0];
    assign o_s_tready  = en0;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_v[NStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v           <= '0;
            r_speed_scale <= mwsm_pkg::ScaleReset;
        end else begin
            if (en0) begin
                r_v[0] <= i_s_tvalid;
            end
            if (ce) begin
                r_v[NStages-1:1] <= r_v[NStages-2:0];
            end
            if (i_cfg_valid) begin
                r_speed_scale <= i_cfg_data;
            end
        end
    end

    // ---- stage 0: capture the command ----
    logic signed [15:0] r_x, r_y, r_w;

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_x <= i_s_tdata[15:0];
            r_y <= i_s_tdata[31:16];
            r_w <= i_s_tdata[47:32];
        end
    end

    // ---- stage 1: squares and 45 degree rotation products ----
    logic        [15:0] aw;
    logic        [12:0] dr;
    logic signed [16:0] dxy, sxy;
    logic signed [31:0] px, py;
    logic signed [34:0] pa, pb;

    logic        [31:0] r_px, r_py;
    logic        [25:0] r_rr;
    logic               r_big;
    logic signed [34:0] r_pa, r_pb;
    logic        [15:0] r_aw1;
    logic signed [15:0] r_w1;

    always_comb begin
        aw  = r_w[15] ? 16'(-r_w) : r_w;
        dr  = 13'(16'd4096 - aw);
        dxy = {r_x[15], r_x} - {r_y[15], r_y};
        sxy = {r_x[15], r_x} + {r_y[15], r_y};
        px  = r_x * r_x;
        py  = r_y * r_y;
        pa  = dxy * $signed({1'b0, mwsm_pkg::InvSqrt2});
        pb  = sxy * $signed({1'b0, mwsm_pkg::InvSqrt2});
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_px  <= px;
            r_py  <= py;
            r_rr  <= dr * dr;
            r_big <= aw > 16'd4096;
            r_pa  <= pa;
            r_pb  <= pb;
            r_aw1 <= aw;
            r_w1  <= r_w;
        end
    end

    // ---- stage 2: limit test, rounded rotation, raw wheels ----
    logic        [31:0]   sq;
    logic        [34:0]   amag, bmag;
    logic        [18:0]   ar, br;
    logic signed [MW-1:0] av, bv, wv;
    mwsm_pkg::t_sqrt_lane front;
    mwsm_pkg::t_sqrt_lane r_front;

    always_comb begin
        sq   = r_px + r_py;
        amag = r_pa[34] ? 35'(-r_pa) : r_pa;
        bmag = r_pb[34] ? 35'(-r_pb) : r_pb;
        ar   = 19'((amag + 35'd32768) >> 16);
        br   = 19'((bmag + 35'd32768) >> 16);
        av   = r_pa[34] ? MW'(-ar) : MW'(ar);
        bv   = r_pb[34] ? MW'(-br) : MW'(br);
        wv   = MW'(r_w1);
        front.rad     = {sq, 12'd0};
        front.rem     = '0;
        front.root    = '0;
        front.m[0]    = av - wv;
        front.m[1]    = bv + wv;
        front.m[2]    = bv - wv;
        front.m[3]    = av + wv;
        front.aw      = r_aw1;
        front.limited = r_big || (sq > {6'd0, r_rr});
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_front <= front;
        end
    end

    // ---- square root chain: one root bit per cell ----
    mwsm_pkg::t_sqrt_lane sq_lane [mwsm_pkg::SqrtCells+1];
    assign sq_lane[0] = r_front;

    for (genvar k = 0; k < mwsm_pkg::SqrtCells; k++) begin : g_sqrt
        mwsm_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_lane (sq_lane[k]),
            .o_lane (sq_lane[k+1])
        );
    end

    // ---- stage D: normalizing sum and rounded dividends ----
    mwsm_pkg::t_sqrt_lane  sl;
    logic [mwsm_pkg::DenW-1:0] sum;
    logic [16:0]           mmag [NW];
    logic [35:0]           num  [NW];
    mwsm_pkg::t_div_lane   dl;
    mwsm_pkg::t_div_lane   r_dl;

    always_comb begin
        sl  = sq_lane[mwsm_pkg::SqrtCells];
        sum = {1'b0, sl.root} + {1'b0, sl.aw, 6'd0};
        dl.den     = sum;
        dl.limited = sl.limited;
        dl.m       = sl.m;
        dl.q       = '0;
        for (int i = 0; i < NW; i++) begin
            mmag[i]   = sl.m[i][MW-1] ? 17'(-sl.m[i]) : sl.m[i][16:0];
            num[i]    = {1'b0, mmag[i], 18'd0} + 36'(sum >> 1);
            dl.neg[i] = sl.m[i][MW-1];
            dl.rem[i] = {4'd0, num[i][35:17]};
            dl.nb[i]  = num[i][16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dl <= dl;
        end
    end

    // ---- divider chain: one quotient bit per cell, all wheels in parallel ----
    mwsm_pkg::t_div_lane dv_lane [mwsm_pkg::DivCells+1];
    assign dv_lane[0] = r_dl;

    for (genvar k = 0; k < mwsm_pkg::DivCells; k++) begin : g_div
        mwsm_div_cell u_cell (
            .i_clk  (i_clk),
            .i_ce   (ce),
            .i_lane (dv_lane[k]),
            .o_lane (dv_lane[k+1])
        );
    end

    // ---- stage E: pick the wheel, apply speed scale ----
    mwsm_pkg::t_div_lane dq;
    logic signed [MW-1:0] wsel [NW];
    logic signed [mwsm_pkg::ProdW-1:0] r_prod [NW];
    logic r_lim_e;

    always_comb begin
        dq = dv_lane[mwsm_pkg::DivCells];
        for (int i = 0; i < NW; i++) begin
            if (dq.limited) begin
                wsel[i] = dq.neg[i] ? MW'(-{1'b0, dq.q[i]}) : MW'({1'b0, dq.q[i]});
            end else begin
                wsel[i] = dq.m[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < NW; i++) begin
                r_prod[i] <= wsel[i] * $signed(r_speed_scale);
            end
            r_lim_e <= dq.limited;
        end
    end

    // ---- stage F: round, saturate, hold for the output transfer ----
    logic        [mwsm_pkg::ProdW-1:0] pmag [NW];
    logic        [26:0]                pr   [NW];
    logic signed [27:0]                ps   [NW];
    logic signed [mwsm_pkg::OutW-1:0]  sat  [NW];
    logic signed [mwsm_pkg::OutW-1:0]  r_out [NW];
    logic                              r_lim;

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            pmag[i] = r_prod[i][mwsm_pkg::ProdW-1] ?
                      mwsm_pkg::ProdW'(-r_prod[i]) : r_prod[i];
            pr[i]   = 27'((pmag[i] + 34'd128) >> 8);
            ps[i]   = r_prod[i][mwsm_pkg::ProdW-1] ? 28'(-{1'b0, pr[i]}) : {1'b0, pr[i]};
            if (ps[i] > 28'(mwsm_pkg::OutMax)) begin
                sat[i] = mwsm_pkg::OutMax;
            end else if (ps[i] < 28'(mwsm_pkg::OutMin)) begin
                sat[i] = mwsm_pkg::OutMin;
            end else begin
                sat[i] = ps[i][mwsm_pkg::OutW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < NW; i++) begin
                r_out[i] <= sat[i];
            end
            r_lim <= r_lim_e;
        end
    end

    assign o_m_tdata = {3'b000, r_lim, r_out[3], r_out[2], r_out[1], r_out[0]};

endmodule

`default_nettype wire
